@@ hdl/dsp_pool_pkg.sv @@
package dsp_pool_pkg;

    localparam int POOL_SLOTS = 32;
    localparam int SLOT_W     = 6;
    localparam int IDX_W      = $clog2(POOL_SLOTS);
    localparam int LEN_W      = $clog2(POOL_SLOTS + 1);

    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] REG_MIN_AMOUNT = 2'd0;
    localparam logic [1:0] REG_MAX_PER_TGT = 2'd1;
    localparam logic [1:0] REG_LIFETIME   = 2'd2;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] target;
        logic [31:0] agg_id;
        logic        merged;
        logic [23:0] amount;
        logic        has_impact;
        logic [15:0] delta_ms;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  slot;
        logic [31:0] serial;
        logic        drift_positive;
        logic [15:0] age_ms;
        logic [15:0] life_ms;
        logic        expiring;
        logic [31:0] owner;
        logic [23:0] shown_amount;
        logic        impact_flag;
        logic        last;
    } out_item_t;

endpackage

@@ hdl/display_slot_pool_with_quota.sv @@
// Slot pool for floating damage numbers. Raise start with an item while
// busy is low; the item is taken at that rising edge. A submit scans all 32
// slots one per cycle and keeps busy high through the scan and the steps to
// pick, hash, write, update the id map and drive the beat, which shows
// together with busy dropping. A submit below min_amount is dropped at once
// without raising busy; one refused by a zero quota (no merge hit and no
// active slot of its target) drops after the pick with no beat. A tick ages,
// then checks and emits each active slot in turn, and a clear finishes at the
// accepting edge without raising busy. Each result beat shows on result for
// exactly one cycle with result_valid high; the receiver cannot stall, so
// capture every beat. last marks the final beat of an item. Configuration
// writes go in only while busy is low.
module display_slot_pool_with_quota (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  dsp_pool_pkg::in_item_t item,
    output logic                   busy,
    output logic                   result_valid,
    output dsp_pool_pkg::out_item_t result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [23:0]            cfg_data
);
    import dsp_pool_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_PICK  = 4'd2;
    localparam logic [3:0] ST_HASH  = 4'd3;
    localparam logic [3:0] ST_WRITE = 4'd4;
    localparam logic [3:0] ST_UNMAP = 4'd5;
    localparam logic [3:0] ST_EMIT  = 4'd6;
    localparam logic [3:0] ST_TAGE  = 4'd7;
    localparam logic [3:0] ST_TCHK  = 4'd8;

    // configuration
    logic [23:0] min_amount_reg;
    logic [6:0]  max_per_target_reg;
    logic [15:0] lifetime_reg;

    // slot stores
    logic [POOL_SLOTS-1:0] active_reg;
    logic [POOL_SLOTS-1:0] mapped_reg;
    logic [31:0] tag_reg    [POOL_SLOTS];
    logic [31:0] owner_reg  [POOL_SLOTS];
    logic [15:0] age_reg    [POOL_SLOTS];
    logic [15:0] life_reg   [POOL_SLOTS];
    logic [31:0] serial_reg [POOL_SLOTS];
    logic [23:0] amount_reg [POOL_SLOTS];
    logic [1:0]  flags_reg  [POOL_SLOTS];
    logic [IDX_W-1:0] list_reg [POOL_SLOTS];
    logic [LEN_W-1:0] len_reg;
    logic [31:0] next_serial_reg;

    logic [3:0]  state_reg;
    in_item_t    req_reg;
    logic [LEN_W-1:0] cnt_reg;
    // scan results
    logic        hit_reg, free_ok_reg, old_ok_reg, own_ok_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg, old_idx_reg, own_idx_reg, sel_reg;
    logic [6:0]  own_cnt_reg;
    logic [31:0] hash_reg;
    logic [31:0] untag_reg;
    logic        restart_reg;

    logic [IDX_W-1:0] ci;
    logic [IDX_W-1:0] li;
    logic [16:0] age_sum;
    assign ci  = cnt_reg[IDX_W-1:0];
    assign li  = list_reg[ci];
    assign age_sum = {1'b0, age_reg[li]} + {1'b0, req_reg.delta_ms};

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_amount_reg     <= '0;
            max_per_target_reg <= 7'd4;
            lifetime_reg       <= 16'd1500;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_AMOUNT:  min_amount_reg     <= cfg_data;
                REG_MAX_PER_TGT: max_per_target_reg <= cfg_data[6:0];
                REG_LIFETIME:    lifetime_reg       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_reg      <= '0;
            mapped_reg      <= '0;
            len_reg         <= '0;
            next_serial_reg <= 32'd1;
            result_valid    <= 1'b0;
            for (int i = 0; i < POOL_SLOTS; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg     <= item;
                        cnt_reg     <= '0;
                        hit_reg     <= 1'b0;
                        free_ok_reg <= 1'b0;
                        old_ok_reg  <= 1'b0;
                        own_ok_reg  <= 1'b0;
                        own_cnt_reg <= '0;
                        case (item.op)
                            OP_SUBMIT:
                                if (item.amount >= min_amount_reg)
                                    state_reg <= ST_SCAN;
                            OP_TICK:
                                if (len_reg != '0)
                                    state_reg <= ST_TAGE;
                            OP_CLEAR:
                            begin
                                // tags of active slots drop; inactive tags are already zero
                                for (int i = 0; i < POOL_SLOTS; i++)
                                    if (active_reg[i])
                                        tag_reg[i] <= '0;
                                active_reg <= '0;
                                mapped_reg <= '0;
                                len_reg    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // one slot per cycle
                    if (req_reg.merged && req_reg.agg_id != '0 && !hit_reg
                        && mapped_reg[ci] && active_reg[ci] && tag_reg[ci] == req_reg.agg_id)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= ci;
                    end
                    if (!active_reg[ci])
                    begin
                        if (!free_ok_reg)
                        begin
                            free_ok_reg  <= 1'b1;
                            free_idx_reg <= ci;
                        end
                    end
                    else
                    begin
                        if (!old_ok_reg || age_reg[ci] > age_reg[old_idx_reg])
                        begin
                            old_ok_reg  <= 1'b1;
                            old_idx_reg <= ci;
                        end
                        if (owner_reg[ci] == req_reg.target)
                        begin
                            own_cnt_reg <= own_cnt_reg + 7'd1;
                            if (!own_ok_reg || age_reg[ci] > age_reg[own_idx_reg])
                            begin
                                own_ok_reg  <= 1'b1;
                                own_idx_reg <= ci;
                            end
                        end
                    end
                    if (cnt_reg == LEN_W'(POOL_SLOTS - 1))
                        state_reg <= ST_PICK;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_PICK:
                begin
                    restart_reg <= !hit_reg;
                    state_reg   <= ST_HASH;
                    if (hit_reg)
                        sel_reg <= hit_idx_reg;
                    else if (own_cnt_reg >= max_per_target_reg)
                    begin
                        sel_reg <= own_idx_reg;
                        if (!own_ok_reg)
                            state_reg <= ST_IDLE;
                    end
                    else if (free_ok_reg)
                        sel_reg <= free_idx_reg;
                    else
                        sel_reg <= old_idx_reg;
                    hash_reg <= next_serial_reg * LCG_MUL;
                end
                ST_HASH:
                begin
                    hash_reg  <= hash_reg + LCG_ADD;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    untag_reg <= '0;
                    if (!active_reg[sel_reg])
                    begin
                        serial_reg[sel_reg] <= next_serial_reg;
                        next_serial_reg <= (next_serial_reg == 32'hFFFF_FFFF) ? 32'd1
                                           : next_serial_reg + 32'd1;
                        flags_reg[sel_reg] <= {req_reg.has_impact, hash_reg[23]};
                        list_reg[len_reg[IDX_W-1:0]] <= sel_reg;
                        len_reg <= len_reg + 1'b1;
                        age_reg[sel_reg]  <= '0;
                        life_reg[sel_reg] <= lifetime_reg;
                    end
                    else
                    begin
                        flags_reg[sel_reg][1] <= req_reg.has_impact;
                        if (tag_reg[sel_reg] != req_reg.agg_id)
                            untag_reg <= tag_reg[sel_reg];
                        if (restart_reg)
                        begin
                            age_reg[sel_reg]  <= '0;
                            life_reg[sel_reg] <= lifetime_reg;
                        end
                    end
                    active_reg[sel_reg] <= 1'b1;
                    owner_reg[sel_reg]  <= req_reg.target;
                    amount_reg[sel_reg] <= req_reg.amount;
                    state_reg <= ST_UNMAP;
                end
                ST_UNMAP:
                begin
                    // drop the old tag and the new id from the map, then map the slot
                    for (int i = 0; i < POOL_SLOTS; i++)
                        if ((untag_reg != '0 && tag_reg[i] == untag_reg)
                            || (req_reg.agg_id != '0 && tag_reg[i] == req_reg.agg_id))
                            mapped_reg[i] <= 1'b0;
                    tag_reg[sel_reg] <= req_reg.agg_id;
                    if (req_reg.agg_id != '0)
                        mapped_reg[sel_reg] <= 1'b1;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    result_valid          <= 1'b1;
                    result.slot           <= SLOT_W'(sel_reg);
                    result.serial         <= serial_reg[sel_reg];
                    result.drift_positive <= flags_reg[sel_reg][0];
                    result.age_ms         <= age_reg[sel_reg];
                    result.life_ms        <= life_reg[sel_reg];
                    result.expiring       <= 1'b0;
                    result.owner          <= owner_reg[sel_reg];
                    result.shown_amount   <= amount_reg[sel_reg];
                    result.impact_flag    <= flags_reg[sel_reg][1];
                    result.last           <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_TAGE:
                begin
                    age_reg[li] <= age_sum[16] ? AGE_MAX : age_sum[15:0];
                    state_reg   <= ST_TCHK;
                end
                ST_TCHK:
                begin
                    result_valid          <= 1'b1;
                    result.slot           <= SLOT_W'(li);
                    result.serial         <= serial_reg[li];
                    result.drift_positive <= flags_reg[li][0];
                    result.age_ms         <= age_reg[li];
                    result.life_ms        <= life_reg[li];
                    result.owner          <= owner_reg[li];
                    result.shown_amount   <= amount_reg[li];
                    result.impact_flag    <= flags_reg[li][1];
                    if (age_reg[li] >= life_reg[li])
                    begin
                        result.expiring <= 1'b1;
                        for (int i = 0; i < POOL_SLOTS; i++)
                            if (tag_reg[li] != '0 && tag_reg[i] == tag_reg[li])
                                mapped_reg[i] <= 1'b0;
                        active_reg[li] <= 1'b0;
                        tag_reg[li]    <= '0;
                        mapped_reg[li] <= 1'b0;
                        list_reg[ci]   <= list_reg[IDX_W'(len_reg - 1'b1)];
                        len_reg        <= len_reg - 1'b1;
                        result.last    <= (cnt_reg == len_reg - 1'b1);
                        state_reg <= (cnt_reg == len_reg - 1'b1) ? ST_IDLE : ST_TAGE;
                    end
                    else
                    begin
                        result.expiring <= 1'b0;
                        cnt_reg         <= cnt_reg + 1'b1;
                        result.last     <= (cnt_reg + 1'b1 == len_reg);
                        state_reg <= (cnt_reg + 1'b1 == len_reg) ? ST_IDLE : ST_TAGE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/dsp_pool_checker.sv @@
module dsp_pool_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    busy,
    input logic                    result_valid,
    input dsp_pool_pkg::out_item_t result,
    input logic                    cfg_ready
);
    import dsp_pool_pkg::*;

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !busy) else $error("cfg_ready while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy)) else $error("result without work");
    a_submit_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last && !busy && result.expiring) |->
        result.age_ms >= result.life_ms) else $error("expiring below life");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy) else $error("last but busy");
endmodule

bind display_slot_pool_with_quota dsp_pool_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .result_valid(result_valid), .result(result), .cfg_ready(cfg_ready)
);
